[design/csvt_pkg.sv]
package csvt_pkg;

    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int MAX_FIELD_BYTES = 512;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;

    localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD_END = 2'd2;

    typedef enum logic [2:0] {
        QM_OUTSIDE    = 3'b001,
        QM_INSIDE     = 3'b010,
        QM_QUOTE_SEEN = 3'b100
    } t_quote_mode;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic              field_truncated;
    } t_tok_res;

endpackage

[design/csvt_if.sv]
interface csvt_byte_if;
    logic                             valid;
    logic                             ready;
    logic [csvt_pkg::BYTE_W-1:0]      in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface csvt_tok_if;
    logic                             valid;
    logic                             ready;
    logic [csvt_pkg::BYTE_W-1:0]      out_byte;
    logic [csvt_pkg::KIND_W-1:0]      kind;
    logic                             field_truncated;

    modport source (output valid, output out_byte, output kind, output field_truncated,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input field_truncated,
                    output ready);
endinterface

[design/csvt_lexer.sv]
module csvt_lexer #(
    parameter int MAX_FIELD_BYTES = csvt_pkg::MAX_FIELD_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [csvt_pkg::BYTE_W-1:0] i_byte,
    output csvt_pkg::t_tok_res          o_res
);

    localparam int LEN_W = $clog2(MAX_FIELD_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FIELD_BYTES);

    csvt_pkg::t_quote_mode r_mode, n_mode;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_drop, n_drop;

    logic                        is_data;
    logic                        is_end;
    logic                        unquoted;
    logic [csvt_pkg::KIND_W-1:0] end_kind;

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_drop   = r_drop;
        is_data  = 1'b0;
        is_end   = 1'b0;
        unquoted = 1'b0;
        end_kind = csvt_pkg::KIND_FIELD_END;
        o_res    = '0;

        if (i_byte == csvt_pkg::CH_NUL) begin
            is_end   = 1'b1;
            end_kind = csvt_pkg::KIND_RECORD_END;
        end else begin
            case (r_mode)
                csvt_pkg::QM_INSIDE: begin
                    if (i_byte == csvt_pkg::CH_QUOTE) begin
                        n_mode = csvt_pkg::QM_QUOTE_SEEN;
                    end else begin
                        is_data = 1'b1;
                    end
                end
                csvt_pkg::QM_QUOTE_SEEN: begin
                    // doubled quote: literal quote, stay quoted
                    if (i_byte == csvt_pkg::CH_QUOTE) begin
                        n_mode  = csvt_pkg::QM_INSIDE;
                        is_data = 1'b1;
                    end else begin
                        unquoted = 1'b1;
                    end
                end
                default: begin
                    unquoted = 1'b1;
                end
            endcase

            if (unquoted) begin
                n_mode = csvt_pkg::QM_OUTSIDE;
                if (i_byte == csvt_pkg::CH_QUOTE) begin
                    n_mode = csvt_pkg::QM_INSIDE;
                end else if (i_byte == csvt_pkg::CH_COMMA) begin
                    is_end = 1'b1;
                end else if (i_byte == csvt_pkg::CH_NL) begin
                    is_end   = 1'b1;
                    end_kind = csvt_pkg::KIND_RECORD_END;
                end else begin
                    is_data = 1'b1;
                end
            end
        end

        if (is_end) begin
            o_res.valid           = 1'b1;
            o_res.kind            = end_kind;
            o_res.field_truncated = r_drop;
            n_len                 = '0;
            n_drop                = 1'b0;
            if (end_kind == csvt_pkg::KIND_RECORD_END) begin
                n_mode = csvt_pkg::QM_OUTSIDE;
            end
        end else if (is_data) begin
            if (r_len >= LEN_MAX) begin
                n_drop = 1'b1;
            end else begin
                n_len          = r_len + LEN_W'(1);
                o_res.valid    = 1'b1;
                o_res.out_byte = i_byte;
                o_res.kind     = csvt_pkg::KIND_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= csvt_pkg::QM_OUTSIDE;
            r_len  <= '0;
            r_drop <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_drop <= n_drop;
        end
    end

endmodule

[design/csv_field_tokenizer_core.sv]
// CSV field tokenizer: splits a byte stream into fields and records.
// i_in  (sink): one character per beat; a zero byte ends the field and the record.
// o_out (source): one token per beat; kind 0 carries a content byte, kind 1
//   ends a field, kind 2 ends field and record. field_truncated is set on a
//   field end if bytes past MAX_FIELD_BYTES were dropped from that field.
// Quoted fields: commas and newlines are literal, a doubled quote is one quote.
// Quotes that open or close quoted mode, the first quote of a pair and dropped bytes
//   produce no token.
// Path: an accepted byte lands in the input register, is classified against
//   the lexer state and its token is registered in the output register,
//   which drives o_out.
// Throughput: one byte per cycle while o_out is ready, set by the state update
//   in the lexer between the input and output registers.
// Stall: while o_out waits, the input register still takes one more beat;
//   i_in.ready then drops until the output register frees.
// Reset (synchronous, active low): both registers empty, quote state outside,
//   field length and dropped flag cleared.
module csv_field_tokenizer_core #(
    parameter int MAX_FIELD_BYTES = csvt_pkg::MAX_FIELD_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csvt_byte_if.sink     i_in,
    csvt_tok_if.source    o_out
);

    logic                        r_in_valid;
    logic [csvt_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_out_valid;
    csvt_pkg::t_tok_res          r_out;
    csvt_pkg::t_tok_res          lex_res;
    logic                        advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    csvt_lexer #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (lex_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= lex_res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && lex_res.valid) begin
            r_out <= lex_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out.out_byte;
    assign o_out.kind            = r_out.kind;
    assign o_out.field_truncated = r_out.field_truncated;

endmodule

[test/csv_field_tokenizer_core_tb.sv]
module csv_field_tokenizer_core_tb;

    localparam int ITEM_TARGET = 1300;
    localparam int HOLD_CYCLES = 300;

    typedef logic [csvt_pkg::BYTE_W-1:0] t_byte;
    typedef logic [csvt_pkg::KIND_W-1:0] t_kind;

    typedef struct {
        t_byte tok_byte;
        t_kind kind;
        logic  truncated;
    } t_lex_token;

    // Tracks the lexer state and the tokens still owed by the block.
    class t_token_scoreboard;
        csvt_pkg::t_quote_mode qmode;
        int unsigned           field_len;
        bit                    dropped;
        t_lex_token            expected_tokens[$];
        int unsigned           mismatches;

        function new();
            qmode      = csvt_pkg::QM_OUTSIDE;
            field_len  = 0;
            dropped    = 0;
            mismatches = 0;
        endfunction

        function void close_field(t_kind k);
            t_lex_token t;
            t.tok_byte  = '0;
            t.kind      = k;
            t.truncated = dropped;
            expected_tokens.push_back(t);
            field_len = 0;
            dropped   = 0;
            if (k == csvt_pkg::KIND_RECORD_END) begin
                qmode = csvt_pkg::QM_OUTSIDE;
            end
        endfunction

        function void keep_byte(t_byte b);
            t_lex_token t;
            if (field_len >= csvt_pkg::MAX_FIELD_BYTES) begin
                dropped = 1;
            end else begin
                field_len++;
                t.tok_byte  = b;
                t.kind      = csvt_pkg::KIND_DATA;
                t.truncated = 1'b0;
                expected_tokens.push_back(t);
            end
        endfunction

        function void note_byte(t_byte b);
            if (b == csvt_pkg::CH_NUL) begin
                close_field(csvt_pkg::KIND_RECORD_END);
            end else if (qmode == csvt_pkg::QM_INSIDE) begin
                if (b == csvt_pkg::CH_QUOTE) begin
                    qmode = csvt_pkg::QM_QUOTE_SEEN;
                end else begin
                    keep_byte(b);
                end
            end else if (qmode == csvt_pkg::QM_QUOTE_SEEN && b == csvt_pkg::CH_QUOTE) begin
                qmode = csvt_pkg::QM_INSIDE;
                keep_byte(b);
            end else begin
                // outside quotes, or a lone quote then another byte: that byte is handled unquoted
                qmode = csvt_pkg::QM_OUTSIDE;
                if (b == csvt_pkg::CH_QUOTE) begin
                    qmode = csvt_pkg::QM_INSIDE;
                end else if (b == csvt_pkg::CH_COMMA) begin
                    close_field(csvt_pkg::KIND_FIELD_END);
                end else if (b == csvt_pkg::CH_NL) begin
                    close_field(csvt_pkg::KIND_RECORD_END);
                end else begin
                    keep_byte(b);
                end
            end
        endfunction

        function void check_token(t_byte b, t_kind k, logic tr);
            t_lex_token e;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected token: byte=%h kind=%0d trunc=%0b", b, k, tr);
                end
                return;
            end
            e = expected_tokens.pop_front();
            if (e.tok_byte !== b || e.kind !== k || e.truncated !== tr) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("token mismatch: exp byte=%h kind=%0d trunc=%0b,",
                             e.tok_byte, e.kind, e.truncated,
                             " got byte=%h kind=%0d trunc=%0b", b, k, tr);
                end
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    csvt_byte_if in_if ();
    csvt_tok_if  out_if ();

    csv_field_tokenizer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_token_scoreboard sb;
    int                burst_left;
    int                sent;
    bit                hold_req;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_token(out_if.out_byte, out_if.kind, out_if.field_truncated);
        end
    end

    initial begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

    // Sink side: stretches of full rate, fixed stall patterns and random stalls,
    // plus one long hold-off on request.
    initial begin
        int          n;
        logic [7:0]  pattern;
        out_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_if.ready = 1'b0;
                end
                hold_req = 0;
            end else begin
                n = int'($urandom_range(20, 100));
                case ($urandom_range(0, 2))
                    0: begin
                        repeat (n) begin
                            @(negedge i_clk);
                            out_if.ready = 1'b1;
                        end
                    end
                    1: begin
                        pattern = 8'($urandom);
                        for (int i = 0; i < n; i++) begin
                            @(negedge i_clk);
                            out_if.ready = pattern[i % 8];
                        end
                    end
                    default: begin
                        repeat (n) begin
                            @(negedge i_clk);
                            out_if.ready = ($urandom_range(0, 3) != 0);
                        end
                    end
                endcase
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_if.valid   = 1'b0;
            in_if.in_byte = t_byte'($urandom);
        end
    endtask

    task automatic send_char(input t_byte b);
        if (burst_left == 0) begin
            idle_cycles(int'($urandom_range(1, 6)));
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(1, 20));
        end
        burst_left--;
        @(negedge i_clk);
        in_if.valid   = 1'b1;
        in_if.in_byte = b;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic t_byte plain_char();
        t_byte b;
        do b = t_byte'($urandom_range(1, 255));
        while (b == csvt_pkg::CH_NL || b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_COMMA);
        return b;
    endfunction

    task automatic send_field(input bit quoted, input int len);
        if (quoted) begin
            send_char(csvt_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_char(csvt_pkg::CH_QUOTE);
                        send_char(csvt_pkg::CH_QUOTE);
                    end
                    1: send_char(csvt_pkg::CH_COMMA);
                    2: send_char(csvt_pkg::CH_NL);
                    default: send_char(plain_char());
                endcase
            end
            send_char(csvt_pkg::CH_QUOTE);
            // text right after the closing quote drops back to unquoted
            if ($urandom_range(0, 9) == 0) begin
                send_char(plain_char());
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                if (len <= 8 && $urandom_range(0, 24) == 0) begin
                    send_char(csvt_pkg::CH_QUOTE);
                end else begin
                    send_char(plain_char());
                end
            end
        end
    endtask

    task automatic send_record(input int long_len, input bit long_quoted);
        int nf;
        nf = int'($urandom_range(1, 4));
        for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
                send_char(csvt_pkg::CH_COMMA);
            end
            if (f == 0 && long_len > 0) begin
                send_field(long_quoted, long_len);
            end else begin
                send_field($urandom_range(0, 2) == 0, int'($urandom_range(0, 8)));
            end
        end
        send_char(($urandom_range(0, 9) == 0) ? csvt_pkg::CH_NUL : csvt_pkg::CH_NL);
    endtask

    initial begin
        t_byte directed [25];
        t_byte specials [4];
        bit    hold_done;
        bit    drain_done;
        bit    long_a;
        bit    long_b;
        int    n;

        directed = '{8'h61, csvt_pkg::CH_COMMA, 8'h62, csvt_pkg::CH_NL,
                     csvt_pkg::CH_QUOTE, 8'h78, csvt_pkg::CH_QUOTE, csvt_pkg::CH_QUOTE,
                     csvt_pkg::CH_COMMA, csvt_pkg::CH_NL, csvt_pkg::CH_QUOTE,
                     8'hFF, csvt_pkg::CH_NUL,
                     8'h70, csvt_pkg::CH_QUOTE, 8'h71, csvt_pkg::CH_QUOTE, csvt_pkg::CH_NL,
                     csvt_pkg::CH_QUOTE, csvt_pkg::CH_QUOTE, csvt_pkg::CH_COMMA,
                     8'h80, 8'h7F, csvt_pkg::CH_NL, csvt_pkg::CH_NUL};
        specials = '{csvt_pkg::CH_QUOTE, csvt_pkg::CH_COMMA, csvt_pkg::CH_NL,
                     csvt_pkg::CH_NUL};
        hold_done  = 0;
        drain_done = 0;
        long_a     = 0;
        long_b     = 0;

        sb            = new();
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        burst_left    = 0;
        sent          = 0;
        hold_req      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            send_char(directed[i]);
        end
        wait_drained();

        while (sent < ITEM_TARGET) begin
            if (!hold_done && sent >= 250) begin
                hold_req  = 1;
                hold_done = 1;
            end
            if (!drain_done && sent >= 700) begin
                wait_drained();
                drain_done = 1;
            end
            if (!long_a && sent >= 100) begin
                // exactly at the length limit: nothing dropped
                send_record(csvt_pkg::MAX_FIELD_BYTES, 0);
                long_a = 1;
            end else if (!long_b && sent >= 700) begin
                send_record(csvt_pkg::MAX_FIELD_BYTES + int'($urandom_range(1, 8)), 1);
                long_b = 1;
            end else if ($urandom_range(0, 6) == 0) begin
                n = int'($urandom_range(1, 8));
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send_char(specials[2'($urandom_range(0, 3))]);
                    end else begin
                        send_char(t_byte'($urandom_range(0, 255)));
                    end
                end
            end else begin
                send_record(0, 0);
            end
        end
        wait_drained();

        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
design/csvt_pkg.sv
design/csvt_if.sv
design/csvt_lexer.sv
design/csv_field_tokenizer_core.sv
test/csv_field_tokenizer_core_tb.sv
